@@ hw/rtl/efsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Earliest-free-server dispatch package
// Shared widths, defaults, result structs and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package efsd_pkg;

	// Field widths of the request and result.
	localparam int TIME_W  = 32;
	localparam int SVC_W   = 16;
	localparam int CNT_W   = 16;
	localparam int IDX_W   = 4;

	// Default number of servers in the bank.
	localparam int NUM_SERVERS_DEF = 3;

	// Outcome of the scheduling decision for one request.
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] wait_t;
		logic [TIME_W-1:0] end_t;
	} sched_t;

	// Updated statistics after one request is committed.
	typedef struct packed {
		logic [CNT_W-1:0]  srv_jobs;
		logic [TIME_W-1:0] srv_busy;
		logic [TIME_W-1:0] srv_wait;
		logic [CNT_W-1:0]  all_jobs;
		logic [TIME_W-1:0] all_busy;
		logic [TIME_W-1:0] all_wait;
	} stats_t;

	// Saturating 32-bit add.
	function automatic logic [TIME_W-1:0] add_sat32(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

	// Saturating 16-bit increment.
	function automatic logic [CNT_W-1:0] inc_sat16(input logic [CNT_W-1:0] a);
		return (a == {CNT_W{1'b1}}) ? a : a + 1'b1;
	endfunction

endpackage

@@ hw/rtl/earliest_free_server_dispatch.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Earliest-free-server dispatch
// Assigns each job to a server of the bank and reports wait, end and totals.
// ----------------------------------------------------------------------------
// Usage:
// A request carries arrival_time and service_time on the input channel
// (in_valid / in_stall); arrivals are expected in non-decreasing order.
// Each request yields exactly one result on the output channel
// (out_valid / out_stall) with the chosen server, the wait, the end time and
// the updated per-server and bank-wide statistics.
// A request is captured in the input register when it is accepted, and
// selection and the statistics update load the output register when the
// request commits. Throughput: one request per cycle. The rate is set by
// the loop of server selection and statistics update through the bank.
// While out_stall holds a pending result, the request in the input register
// waits and in_stall rises; nothing is dropped.
// Reset clears all counts, totals and end times to zero and empties both
// registers.
// ----------------------------------------------------------------------------
module earliest_free_server_dispatch #(
	parameter int NUM_SERVERS = efsd_pkg::NUM_SERVERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [efsd_pkg::TIME_W-1:0]   arrival_time,
	input  logic [efsd_pkg::SVC_W-1:0]    service_time,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [efsd_pkg::IDX_W-1:0]    server_index,
	output logic [efsd_pkg::TIME_W-1:0]   wait_time,
	output logic [efsd_pkg::TIME_W-1:0]   end_time,
	output logic [efsd_pkg::CNT_W-1:0]    server_job_count,
	output logic [efsd_pkg::TIME_W-1:0]   server_busy_total,
	output logic [efsd_pkg::TIME_W-1:0]   server_wait_total,
	output logic [efsd_pkg::CNT_W-1:0]    all_job_count,
	output logic [efsd_pkg::TIME_W-1:0]   all_busy_total,
	output logic [efsd_pkg::TIME_W-1:0]   all_wait_total
);

	logic                                          valid_s1;
	logic [efsd_pkg::TIME_W-1:0]                   arrival_s1;
	logic [efsd_pkg::SVC_W-1:0]                    service_s1;
	logic                                          out_free;
	logic                                          commit;
	logic                                          in_accept;
	logic [NUM_SERVERS-1:0]                        used;
	logic [NUM_SERVERS-1:0][efsd_pkg::TIME_W-1:0]  last_end;
	efsd_pkg::sched_t                              sched;
	efsd_pkg::stats_t                              stats;

	// Handshake: the output register frees up when empty or being taken.
	assign out_free  = !out_valid || !out_stall;
	assign commit    = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			arrival_s1 <= arrival_time;
			service_s1 <= service_time;
		end
	end

	// Server selection and timing.
	efsd_sched #(
		.NUM_SERVERS (NUM_SERVERS)
	) u_sched (
		.used     (used),
		.last_end (last_end),
		.arrival  (arrival_s1),
		.service  (service_s1),
		.sched    (sched)
	);

	// Per-server and bank-wide state.
	efsd_bank #(
		.NUM_SERVERS (NUM_SERVERS)
	) u_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (commit),
		.sched    (sched),
		.service  (service_s1),
		.used     (used),
		.last_end (last_end),
		.stats    (stats)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			server_index      <= sched.idx;
			wait_time         <= sched.wait_t;
			end_time          <= sched.end_t;
			server_job_count  <= stats.srv_jobs;
			server_busy_total <= stats.srv_busy;
			server_wait_total <= stats.srv_wait;
			all_job_count     <= stats.all_jobs;
			all_busy_total    <= stats.all_busy;
			all_wait_total    <= stats.all_wait;
		end
	end

`ifndef ASSERT_OFF
	// A request held in the input register while the output is blocked stays put.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !commit |=> valid_s1 && $stable(arrival_s1) && $stable(service_s1))
		else $error("input register lost or changed a waiting request");

	// Every commit produces a result with a server inside the bank.
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid && (server_index < NUM_SERVERS))
		else $error("committed request did not produce a valid result");

	// The bank-wide job count never trails the chosen server's count.
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> all_job_count >= server_job_count)
		else $error("bank job count below server job count");

	// The input side stalls only while a request is blocked in the input register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked request");
`endif

endmodule

@@ hw/rtl/efsd_sched.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Server selection
// Picks the first unused server, or else the server whose last job ends
// earliest, and works out the wait and end time of the request.
// ----------------------------------------------------------------------------
module efsd_sched #(
	parameter int NUM_SERVERS = efsd_pkg::NUM_SERVERS_DEF
) (
	input  logic [NUM_SERVERS-1:0]                        used,
	input  logic [NUM_SERVERS-1:0][efsd_pkg::TIME_W-1:0]  last_end,
	input  logic [efsd_pkg::TIME_W-1:0]                   arrival,
	input  logic [efsd_pkg::SVC_W-1:0]                    service,
	output efsd_pkg::sched_t                              sched
);

	localparam int LEVELS = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 0;
	localparam int LEAVES = 1 << LEVELS;
	localparam int NODES  = 2 * LEAVES - 1;

	logic [NODES-1:0][efsd_pkg::TIME_W-1:0] node_val;
	logic [NODES-1:0][efsd_pkg::IDX_W-1:0]  node_idx;
	logic                                   free_found;
	logic [efsd_pkg::IDX_W-1:0]             free_idx;
	logic [efsd_pkg::TIME_W-1:0]            min_end;
	logic [efsd_pkg::TIME_W-1:0]            start;

	// Lowest-numbered server that has never taken a job.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SERVERS - 1; i >= 0; i--) begin
			if (!used[i]) begin
				free_found = 1'b1;
				free_idx   = efsd_pkg::IDX_W'(i);
			end
		end
	end

	// Compare tree for the earliest end time; the left branch wins ties, and
	// padding leaves hold the largest value so they never beat a real server.
	always_comb begin
		node_val = '0;
		node_idx = '0;
		for (int i = 0; i < LEAVES; i++) begin
			if (i < NUM_SERVERS) begin
				node_val[LEAVES-1+i] = last_end[i];
			end else begin
				node_val[LEAVES-1+i] = {efsd_pkg::TIME_W{1'b1}};
			end
			node_idx[LEAVES-1+i] = efsd_pkg::IDX_W'(i);
		end
		for (int k = LEAVES - 2; k >= 0; k--) begin
			if (node_val[2*k+2] < node_val[2*k+1]) begin
				node_val[k] = node_val[2*k+2];
				node_idx[k] = node_idx[2*k+2];
			end else begin
				node_val[k] = node_val[2*k+1];
				node_idx[k] = node_idx[2*k+1];
			end
		end
	end

	assign min_end = node_val[0];

	// Service starts at the later of the server's last end and the arrival.
	always_comb begin
		sched = '0;
		if (free_found) begin
			sched.idx    = free_idx;
			sched.wait_t = '0;
			start        = arrival;
		end else begin
			sched.idx = node_idx[0];
			if (min_end > arrival) begin
				sched.wait_t = min_end - arrival;
				start        = min_end;
			end else begin
				sched.wait_t = '0;
				start        = arrival;
			end
		end
		sched.end_t = efsd_pkg::add_sat32(start,
			{{(efsd_pkg::TIME_W-efsd_pkg::SVC_W){1'b0}}, service});
	end

endmodule

@@ hw/rtl/efsd_bank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Server statistics bank
// Holds per-server and bank-wide counts, totals and last end times, and
// updates the chosen server when a request is committed.
// ----------------------------------------------------------------------------
module efsd_bank #(
	parameter int NUM_SERVERS = efsd_pkg::NUM_SERVERS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          commit,
	input  efsd_pkg::sched_t                              sched,
	input  logic [efsd_pkg::SVC_W-1:0]                    service,
	output logic [NUM_SERVERS-1:0]                        used,
	output logic [NUM_SERVERS-1:0][efsd_pkg::TIME_W-1:0]  last_end,
	output efsd_pkg::stats_t                              stats
);

	logic [NUM_SERVERS-1:0][efsd_pkg::CNT_W-1:0]  job_count_q;
	logic [NUM_SERVERS-1:0][efsd_pkg::TIME_W-1:0] busy_total_q;
	logic [NUM_SERVERS-1:0][efsd_pkg::TIME_W-1:0] wait_total_q;
	logic [NUM_SERVERS-1:0][efsd_pkg::TIME_W-1:0] last_end_q;
	logic [efsd_pkg::CNT_W-1:0]                   sum_jobs_q;
	logic [efsd_pkg::TIME_W-1:0]                  sum_busy_q;
	logic [efsd_pkg::TIME_W-1:0]                  sum_wait_q;

	logic [NUM_SERVERS-1:0]      sel;
	logic [efsd_pkg::CNT_W-1:0]  cur_jobs;
	logic [efsd_pkg::TIME_W-1:0] cur_busy;
	logic [efsd_pkg::TIME_W-1:0] cur_wait;
	logic [efsd_pkg::TIME_W-1:0] svc_ext;

	assign svc_ext = {{(efsd_pkg::TIME_W-efsd_pkg::SVC_W){1'b0}}, service};

	// One-hot select of the chosen server and readout of its current totals.
	always_comb begin
		cur_jobs = '0;
		cur_busy = '0;
		cur_wait = '0;
		for (int i = 0; i < NUM_SERVERS; i++) begin
			sel[i]   = (sched.idx == efsd_pkg::IDX_W'(i));
			cur_jobs = cur_jobs | (job_count_q[i] & {efsd_pkg::CNT_W{sel[i]}});
			cur_busy = cur_busy | (busy_total_q[i] & {efsd_pkg::TIME_W{sel[i]}});
			cur_wait = cur_wait | (wait_total_q[i] & {efsd_pkg::TIME_W{sel[i]}});
		end
	end

	// Updated values, also presented as the result statistics.
	always_comb begin
		stats.srv_jobs = efsd_pkg::inc_sat16(cur_jobs);
		stats.srv_busy = efsd_pkg::add_sat32(cur_busy, svc_ext);
		stats.srv_wait = efsd_pkg::add_sat32(cur_wait, sched.wait_t);
		stats.all_jobs = efsd_pkg::inc_sat16(sum_jobs_q);
		stats.all_busy = efsd_pkg::add_sat32(sum_busy_q, svc_ext);
		stats.all_wait = efsd_pkg::add_sat32(sum_wait_q, sched.wait_t);
	end

	// State registers; only the chosen server changes on a commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_count_q  <= '0;
			busy_total_q <= '0;
			wait_total_q <= '0;
			last_end_q   <= '0;
			sum_jobs_q   <= '0;
			sum_busy_q   <= '0;
			sum_wait_q   <= '0;
		end else if (commit) begin
			for (int i = 0; i < NUM_SERVERS; i++) begin
				if (sel[i]) begin
					job_count_q[i]  <= stats.srv_jobs;
					busy_total_q[i] <= stats.srv_busy;
					wait_total_q[i] <= stats.srv_wait;
					last_end_q[i]   <= sched.end_t;
				end
			end
			sum_jobs_q <= stats.all_jobs;
			sum_busy_q <= stats.all_busy;
			sum_wait_q <= stats.all_wait;
		end
	end

	// A saturated count stays nonzero, so a used server never looks free.
	always_comb begin
		for (int i = 0; i < NUM_SERVERS; i++) begin
			used[i] = (job_count_q[i] != '0);
		end
	end

	assign last_end = last_end_q;

endmodule
